// ===== rtl/per_pixel_point_light_shading_top_macros.svh =====
`ifndef PER_PIXEL_POINT_LIGHT_SHADING_TOP_MACROS_SVH
`define PER_PIXEL_POINT_LIGHT_SHADING_TOP_MACROS_SVH

// check that is switched off while reset is held
`define PPLS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ppls check failed");

// check that also covers the reset cycles
`define PPLS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("ppls reset check failed");

`endif

// ===== rtl/ppls_pkg.sv =====
package ppls_pkg;

    localparam int DIV_W    = 56;
    localparam int MUL_W    = 33;
    localparam int SQ_STEPS = 32;

    localparam logic [30:0] LEVEL_MAX   = 31'h7FFF_FFFF;
    localparam logic [DIV_W-1:0] DIFFUSE_MIN = DIV_W'(3277);
    localparam logic [48:0] SPEC_CAP    = 49'h0_8000_0000;

    typedef enum logic [2:0] {
        REG_CAM_X,
        REG_CAM_Y,
        REG_CAM_Z,
        REG_SUN_X,
        REG_SUN_Y,
        REG_SUN_Z,
        REG_SUN_POW,
        REG_AMBIENT
    } t_reg;

    typedef enum logic {
        ACT_SHADE,
        ACT_LOAD
    } t_act;

    typedef enum logic [1:0] {
        DOT_SUN,
        DOT_NL,
        DOT_RC
    } t_dot;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_UV_MUL,
        ST_UV_ACC,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_UV_DIV,
        ST_UV_DIVW,
        ST_DOT_MUL,
        ST_DOT_ACC,
        ST_DOT_END,
        ST_SUN_ADD,
        ST_LT_RD,
        ST_LT_CHK,
        ST_LT_D2,
        ST_PRE_W,
        ST_DIF_ISS,
        ST_DIF_MUL,
        ST_DIF_W,
        ST_R_MUL,
        ST_R_ACC,
        ST_SP_MUL,
        ST_SP_ACC,
        ST_SP_DIV,
        ST_SP_W,
        ST_NEXT,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [31:0]        pw;
    } t_light;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
    } t_div_rsp;

    typedef struct packed {
        logic        start;
        logic [63:0] val;
    } t_sq_req;

    typedef struct packed {
        logic        done;
        logic [32:0] root;
    } t_sq_rsp;

endpackage

// ===== rtl/ppls_if.sv =====
interface ppls_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [2:0]         slot;
    logic [31:0]        power;

    modport source (output valid, action, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                    slot, power, input ready);
    modport sink (input valid, action, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                  slot, power, output ready);
endinterface

interface ppls_out_if;
    logic        valid;
    logic        ready;
    logic [30:0] light_level;

    modport source (output valid, light_level, input ready);
    modport sink (input valid, light_level, output ready);
endinterface

// ===== rtl/per_pixel_point_light_shading_top.sv =====
// each lit light slot makes up to six passes through the 56-step shared divider and one 32-step root
// one shade word at a time; a load word is taken while idle
// results wait in an output register, so loads are taken while a result is pending
// synchronous active-low reset clears state, config, output valid and light valid bits, not the table or datapath
module per_pixel_point_light_shading_top #(
    parameter int NUM_LIGHTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ppls_in_if.sink     i_pix,
    ppls_out_if.source  o_lvl,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    import ppls_pkg::*;

    localparam int LW = (NUM_LIGHTS > 1) ? $clog2(NUM_LIGHTS) : 1;
    localparam logic [1:0] AXIS_LAST = 2'd2;
    localparam logic [2:0] SQ_LAST   = 3'd4;

    function automatic logic [30:0] sat_add(logic [30:0] a, logic [63:0] b);
        if (b >= 64'(LEVEL_MAX - a)) begin
            return LEVEL_MAX;
        end
        return a + b[30:0];
    endfunction

    t_state r_state, n_state;

    logic signed [31:0] r_cam [3];
    logic signed [15:0] r_sun [3];
    logic [23:0]        r_sun_pow;
    logic [23:0]        r_amb;

    t_light              r_mem [NUM_LIGHTS];
    logic [NUM_LIGHTS-1:0] r_valid;
    t_light              r_ent;
    logic                r_ent_v;

    logic signed [31:0] r_p [3];
    logic signed [15:0] r_n [3];
    logic signed [32:0] r_d [3];
    logic signed [17:0] r_c [3];
    logic signed [17:0] r_l [3];
    logic signed [23:0] r_r [3];
    logic [63:0]        r_s;
    logic [33:0]        r_len;
    logic signed [47:0] r_acc;
    logic [49:0]        r_d2;
    logic [19:0]        r_a14;
    logic [48:0]        r_x;
    logic [30:0]        r_tot;
    logic [1:0]         r_i;
    logic [2:0]         r_j;
    logic [LW-1:0]      r_k;
    logic               r_cam_pass;
    t_dot               r_dot;
    logic               r_ovalid;
    logic [30:0]        r_olvl;

    t_div_req div_req;
    t_div_rsp div_rsp;
    t_sq_req  sq_req;
    t_sq_rsp  sq_rsp;

    logic signed [MUL_W-1:0]   m_a, m_b;
    logic signed [2*MUL_W-1:0] m_p;

    logic signed [32:0] d_sel;
    logic [31:0]        d_mag;
    logic signed [47:0] acc_neg;
    logic [49:0]        d2_cur;
    logic [31:0]        x_cap;
    logic signed [2*MUL_W-1:0] r_tw;
    logic signed [2*MUL_W-1:0] r_q;
    logic [17:0]        u_val;
    logic               in_acc;
    logic               k_last;
    logic               wr_ok;
    logic [LW-1:0]      w_idx;

    ppls_mul u_mul (.i_clk(i_clk), .i_a(m_a), .i_b(m_b), .o_p(m_p));
    ppls_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));
    ppls_isqrt u_sq (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(sq_req), .o_rsp(sq_rsp));

    assign i_pix.ready       = (r_state == ST_IDLE);
    assign o_lvl.valid       = r_ovalid;
    assign o_lvl.light_level = r_olvl;

    assign in_acc  = i_pix.valid && i_pix.ready;
    assign d_sel   = r_d[r_i];
    assign d_mag   = d_sel[32] ? 32'(-d_sel) : d_sel[31:0];
    assign acc_neg = -r_acc;
    assign d2_cur  = r_s[63:14];
    assign x_cap   = (r_x > SPEC_CAP) ? SPEC_CAP[31:0] : r_x[31:0];
    assign r_tw    = m_p <<< 1;
    assign r_q     = r_tw[2*MUL_W-1] ? -((-r_tw) >>> 14) : (r_tw >>> 14);
    assign u_val   = d_sel[32] ? -div_rsp.quo[17:0] : div_rsp.quo[17:0];
    assign k_last  = (r_k == LW'(NUM_LIGHTS - 1));
    assign wr_ok   = (32'(i_pix.slot) < 32'(NUM_LIGHTS));
    assign w_idx   = LW'(i_pix.slot);

    // next state and unit requests
    always_comb begin
        n_state       = r_state;
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = DIV_W'(r_d2);
        sq_req.start  = 1'b0;
        sq_req.val    = r_s;
        m_a           = '0;
        m_b           = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && i_pix.action == ACT_SHADE) begin
                    n_state = ST_UV_MUL;
                end
            end
            ST_UV_MUL: begin
                m_a     = $signed({1'b0, d_mag});
                m_b     = $signed({1'b0, d_mag});
                n_state = ST_UV_ACC;
            end
            ST_UV_ACC: begin
                n_state = (r_i == AXIS_LAST) ? ST_SQ_GO : ST_UV_MUL;
            end
            ST_SQ_GO: begin
                sq_req.start = 1'b1;
                n_state      = ST_SQ_WAIT;
            end
            ST_SQ_WAIT: begin
                if (sq_rsp.done) begin
                    n_state = ST_UV_DIV;
                end
            end
            ST_UV_DIV: begin
                if (r_len == '0) begin
                    if (r_i == AXIS_LAST) begin
                        n_state = r_cam_pass ? ST_DOT_MUL : ST_LT_D2;
                    end
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = DIV_W'({d_mag, 14'b0});
                    div_req.den   = DIV_W'(r_len);
                    n_state       = ST_UV_DIVW;
                end
            end
            ST_UV_DIVW: begin
                if (div_rsp.done) begin
                    if (r_i == AXIS_LAST) begin
                        n_state = r_cam_pass ? ST_DOT_MUL : ST_LT_D2;
                    end else begin
                        n_state = ST_UV_DIV;
                    end
                end
            end
            ST_DOT_MUL: begin
                unique case (r_dot)
                    DOT_SUN: begin
                        m_a = MUL_W'(r_n[r_i]);
                        m_b = MUL_W'(r_sun[r_i]);
                    end
                    DOT_NL: begin
                        m_a = MUL_W'(r_n[r_i]);
                        m_b = MUL_W'(r_l[r_i]);
                    end
                    default: begin
                        m_a = MUL_W'(r_r[r_i]);
                        m_b = MUL_W'(r_c[r_i]);
                    end
                endcase
                n_state = ST_DOT_ACC;
            end
            ST_DOT_ACC: begin
                n_state = (r_i == AXIS_LAST) ? ST_DOT_END : ST_DOT_MUL;
            end
            ST_DOT_END: begin
                unique case (r_dot)
                    DOT_SUN: begin
                        if (!acc_neg[47] && acc_neg != '0) begin
                            m_a     = MUL_W'(acc_neg);
                            m_b     = $signed({9'b0, r_sun_pow});
                            n_state = ST_SUN_ADD;
                        end else begin
                            n_state = ST_LT_RD;
                        end
                    end
                    DOT_NL: begin
                        n_state = acc_neg[47] ? ST_NEXT : ST_DIF_ISS;
                    end
                    default: begin
                        n_state = (!r_acc[47] && r_acc != '0) ? ST_SP_MUL : ST_NEXT;
                    end
                endcase
            end
            ST_SUN_ADD: begin
                n_state = ST_LT_RD;
            end
            ST_LT_RD: begin
                n_state = ST_LT_CHK;
            end
            ST_LT_CHK: begin
                n_state = (!r_ent_v || r_ent.pw == '0) ? ST_NEXT : ST_UV_MUL;
            end
            ST_LT_D2: begin
                if (d2_cur == '0) begin
                    n_state = ST_NEXT;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = DIV_W'({r_ent.pw, 16'b0});
                    div_req.den   = DIV_W'(d2_cur);
                    n_state       = ST_PRE_W;
                end
            end
            ST_PRE_W: begin
                if (div_rsp.done) begin
                    n_state = (div_rsp.quo < DIFFUSE_MIN) ? ST_NEXT : ST_DOT_MUL;
                end
            end
            ST_DIF_ISS: begin
                m_a     = $signed({13'b0, r_a14});
                m_b     = $signed({1'b0, r_ent.pw});
                n_state = ST_DIF_MUL;
            end
            ST_DIF_MUL: begin
                div_req.start = 1'b1;
                div_req.num   = DIV_W'({m_p[51:0], 2'b00});
                n_state       = ST_DIF_W;
            end
            ST_DIF_W: begin
                if (div_rsp.done) begin
                    n_state = ST_R_MUL;
                end
            end
            ST_R_MUL: begin
                m_a     = MUL_W'(r_n[r_i]);
                m_b     = $signed({13'b0, r_a14});
                n_state = ST_R_ACC;
            end
            ST_R_ACC: begin
                n_state = (r_i == AXIS_LAST) ? ST_DOT_MUL : ST_R_MUL;
            end
            ST_SP_MUL: begin
                m_a     = $signed({1'b0, x_cap});
                m_b     = $signed({1'b0, x_cap});
                n_state = ST_SP_ACC;
            end
            ST_SP_ACC: begin
                n_state = (r_j == SQ_LAST) ? ST_SP_DIV : ST_SP_MUL;
            end
            ST_SP_DIV: begin
                div_req.start = 1'b1;
                div_req.num   = DIV_W'({x_cap, 22'b0});
                n_state       = ST_SP_W;
            end
            ST_SP_W: begin
                if (div_rsp.done) begin
                    n_state = ST_NEXT;
                end
            end
            ST_NEXT: begin
                n_state = k_last ? ST_FIN : ST_LT_RD;
            end
            ST_FIN: begin
                if (!r_ovalid || o_lvl.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam     <= '{default: '0};
            r_sun     <= '{default: '0};
            r_sun_pow <= '0;
            r_amb     <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg'(i_cfg_idx))
                REG_CAM_X:   r_cam[0]  <= i_cfg_data;
                REG_CAM_Y:   r_cam[1]  <= i_cfg_data;
                REG_CAM_Z:   r_cam[2]  <= i_cfg_data;
                REG_SUN_X:   r_sun[0]  <= i_cfg_data[15:0];
                REG_SUN_Y:   r_sun[1]  <= i_cfg_data[15:0];
                REG_SUN_Z:   r_sun[2]  <= i_cfg_data[15:0];
                REG_SUN_POW: r_sun_pow <= i_cfg_data[23:0];
                REG_AMBIENT: r_amb     <= i_cfg_data[23:0];
            endcase
        end
    end

    // light table
    always_ff @(posedge i_clk) begin
        if (in_acc && i_pix.action == ACT_LOAD && wr_ok) begin
            r_mem[w_idx] <= '{px: i_pix.pos_x, py: i_pix.pos_y, pz: i_pix.pos_z,
                              pw: i_pix.power};
        end
        r_ent <= r_mem[r_k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ent_v <= 1'b0;
        end else begin
            if (in_acc && i_pix.action == ACT_LOAD && wr_ok) begin
                r_valid[w_idx] <= 1'b1;
            end
            r_ent_v <= r_valid[r_k];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == ST_FIN && (!r_ovalid || o_lvl.ready)) begin
            r_ovalid <= 1'b1;
        end else if (o_lvl.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN && (!r_ovalid || o_lvl.ready)) begin
            r_olvl <= r_tot;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_p[0]     <= i_pix.pos_x;
                r_p[1]     <= i_pix.pos_y;
                r_p[2]     <= i_pix.pos_z;
                r_n[0]     <= i_pix.norm_x;
                r_n[1]     <= i_pix.norm_y;
                r_n[2]     <= i_pix.norm_z;
                r_d[0]     <= 33'(r_cam[0]) - 33'(i_pix.pos_x);
                r_d[1]     <= 33'(r_cam[1]) - 33'(i_pix.pos_y);
                r_d[2]     <= 33'(r_cam[2]) - 33'(i_pix.pos_z);
                r_cam_pass <= 1'b1;
                r_i        <= '0;
                r_k        <= '0;
                r_s        <= '0;
                r_tot      <= {7'b0, r_amb};
                r_dot      <= DOT_SUN;
                r_acc      <= '0;
            end
            ST_UV_ACC: begin
                r_s <= r_s + {2'b0, m_p[63:2]};
                r_i <= (r_i == AXIS_LAST) ? 2'd0 : r_i + 2'd1;
            end
            ST_SQ_WAIT: begin
                if (sq_rsp.done) begin
                    r_len <= {sq_rsp.root, 1'b0};
                end
            end
            ST_UV_DIV: begin
                if (r_len == '0) begin
                    if (r_cam_pass) begin
                        r_c[r_i] <= '0;
                    end else begin
                        r_l[r_i] <= '0;
                    end
                    r_i <= (r_i == AXIS_LAST) ? 2'd0 : r_i + 2'd1;
                end
            end
            ST_UV_DIVW: begin
                if (div_rsp.done) begin
                    if (r_cam_pass) begin
                        r_c[r_i] <= u_val;
                    end else begin
                        r_l[r_i] <= u_val;
                    end
                    r_i <= (r_i == AXIS_LAST) ? 2'd0 : r_i + 2'd1;
                end
            end
            ST_DOT_ACC: begin
                r_acc <= r_acc + 48'(m_p);
                r_i   <= (r_i == AXIS_LAST) ? 2'd0 : r_i + 2'd1;
            end
            ST_DOT_END: begin
                r_a14 <= acc_neg[33:14];
                r_x   <= 49'(r_acc[46:14]);
                r_j   <= '0;
            end
            ST_SUN_ADD: begin
                r_tot <= sat_add(r_tot, 64'(m_p[63:28]));
                r_k   <= '0;
            end
            ST_LT_CHK: begin
                r_d[0]     <= 33'(r_p[0]) - 33'(r_ent.px);
                r_d[1]     <= 33'(r_p[1]) - 33'(r_ent.py);
                r_d[2]     <= 33'(r_p[2]) - 33'(r_ent.pz);
                r_cam_pass <= 1'b0;
                r_i        <= '0;
                r_s        <= '0;
            end
            ST_LT_D2: begin
                r_d2 <= d2_cur;
            end
            ST_PRE_W: begin
                r_dot <= DOT_NL;
                r_acc <= '0;
                r_i   <= '0;
            end
            ST_DIF_W: begin
                if (div_rsp.done) begin
                    r_tot <= sat_add(r_tot, 64'(div_rsp.quo));
                end
                r_i <= '0;
            end
            ST_R_ACC: begin
                r_r[r_i] <= 24'(r_l[r_i]) + r_q[23:0];
                r_i      <= (r_i == AXIS_LAST) ? 2'd0 : r_i + 2'd1;
                r_dot    <= DOT_RC;
                r_acc    <= '0;
            end
            ST_SP_ACC: begin
                r_x <= m_p[62:14];
                r_j <= r_j + 3'd1;
            end
            ST_SP_W: begin
                if (div_rsp.done) begin
                    r_tot <= sat_add(r_tot, 64'(div_rsp.quo));
                end
            end
            ST_NEXT: begin
                if (!k_last) begin
                    r_k <= r_k + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end
endmodule

// ===== rtl/ppls_mul.sv =====
module ppls_mul (
    input  logic                                i_clk,
    input  logic signed [ppls_pkg::MUL_W-1:0]   i_a,
    input  logic signed [ppls_pkg::MUL_W-1:0]   i_b,
    output logic signed [2*ppls_pkg::MUL_W-1:0] o_p
);
    import ppls_pkg::*;

    logic signed [2*MUL_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule

// ===== rtl/ppls_div.sv =====
module ppls_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ppls_pkg::t_div_req i_req,
    output ppls_pkg::t_div_rsp o_rsp
);
    import ppls_pkg::*;

    localparam int CW = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] r_rem, n_rem;
    logic [DIV_W-1:0] r_quo, n_quo;
    logic [DIV_W-1:0] r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;

    always_comb begin
        logic [DIV_W:0] t;
        t = {r_rem, r_quo[DIV_W-1]};
        if (t >= {1'b0, r_den}) begin
            n_rem = DIV_W'(t - {1'b0, r_den});
            n_quo = {r_quo[DIV_W-2:0], 1'b1};
        end else begin
            n_rem = t[DIV_W-1:0];
            n_quo = {r_quo[DIV_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule

// ===== rtl/ppls_isqrt.sv =====
module ppls_isqrt (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ppls_pkg::t_sq_req i_req,
    output ppls_pkg::t_sq_rsp o_rsp
);
    import ppls_pkg::*;

    localparam int CW = $clog2(SQ_STEPS + 1);

    logic [63:0]   r_v, n_v;
    logic [63:0]   r_r, n_r;
    logic [62:0]   r_bit;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    always_comb begin
        logic [64:0] sum;
        sum = {1'b0, r_r} + {2'b0, r_bit};
        if ({1'b0, r_v} >= sum) begin
            n_v = r_v - sum[63:0];
            n_r = (r_r >> 1) + {1'b0, r_bit};
        end else begin
            n_v = r_v;
            n_r = r_r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(SQ_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_v   <= i_req.val;
            r_r   <= '0;
            r_bit <= {1'b1, 62'b0};
        end else if (r_busy) begin
            r_v   <= n_v;
            r_r   <= n_r;
            r_bit <= r_bit >> 2;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_r[32:0];
endmodule

// ===== rtl/ppls_chk.sv =====
`include "per_pixel_point_light_shading_top_macros.svh"

module ppls_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_action,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [30:0] i_level
);
    import ppls_pkg::*;

    // a stalled result word stays offered
    `PPLS_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)

    // a shade word keeps the block busy in the next cycle
    `PPLS_ASSERT(a_busy, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_action == ACT_SHADE |=> !i_in_ready)

    // no result appears straight after a shade word is taken
    `PPLS_ASSERT(a_no_fast, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_action == ACT_SHADE |=> !$rose(i_out_valid))

    // reset empties the output register
    `PPLS_ASSERT_ALWAYS(a_rst, i_clk, !i_rst_n |=> !i_out_valid && $stable(i_rst_n) || i_rst_n)

    logic unused_level;
    assign unused_level = ^i_level;
endmodule

bind per_pixel_point_light_shading_top ppls_chk u_ppls_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_in_action (i_pix.action),
    .i_out_valid (o_lvl.valid),
    .i_out_ready (o_lvl.ready),
    .i_level     (o_lvl.light_level)
);
